[hdl/cgsl_pkg.sv]
// ----------------------------------------------------------------------------
// cgsl_pkg
// Shared types and constants for the gradient stop lookup block.
// ----------------------------------------------------------------------------
package cgsl_pkg;

    localparam int POS_W    = 17;
    localparam int COLOR_W  = 24;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int SLOT_W   = 4;
    localparam int PROD_W   = CH_W + POS_W;
    localparam int DVS_W    = POS_W + CH_W - 1;
    localparam int ENTRY_W  = POS_W + COLOR_W;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode              opcode;
        logic [SLOT_W-1:0]    slot;
        logic [POS_W-1:0]     position;
        logic [COLOR_W-1:0]   color;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0]   color_out;
        logic                 hit;
        logic                 empty_error;
    } t_out_item;

    typedef struct packed {
        logic                 has_a;
        logic                 has_b;
        logic [POS_W-1:0]     pos_a;
        logic [POS_W-1:0]     pos_b;
        logic [COLOR_W-1:0]   color_a;
        logic [COLOR_W-1:0]   color_b;
    } t_scan_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESOLVE,
        ST_BLEND,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        BL_IDLE,
        BL_MUL0,
        BL_MUL1,
        BL_DIV
    } t_blend_ph;

endpackage

[hdl/color_gradient_stop_lookup.sv]
// ----------------------------------------------------------------------------
// color_gradient_stop_lookup
// Gradient stop table with write, delete, clear and interpolated color lookup.
// Write, delete and clear go straight to the done state; a lookup scans all
// MAX_STOPS slots, then resolves, and when interpolated blends the 3 channels
// in turn on a shared multiplier and a 1-bit-per-cycle divide before done.
// One transaction at a time; the next can be accepted the cycle after the result is loaded.
// Reset (synchronous, active low) clears all stop valid bits and the sequencer.
// ----------------------------------------------------------------------------
module color_gradient_stop_lookup
    import cgsl_pkg::*;
#(
    parameter int MAX_STOPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IW = $clog2(MAX_STOPS);

    t_state              r_state;
    t_state              n_state;
    logic [MAX_STOPS-1:0] r_valid;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_live;
    logic [POS_W-1:0]    r_key;
    logic [COLOR_W-1:0]  r_color;
    logic                r_hit;
    logic                r_err;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_accept;
    logic                w_slot_ok;
    logic [IW-1:0]       w_slot_idx;
    logic                w_wr_en;
    logic                w_rd_en;
    logic                w_load_out;
    logic                w_interp;
    logic                w_blend_start;
    logic [ENTRY_W-1:0]  w_rd_data;
    t_scan_res           w_res;
    logic                w_blend_done;
    logic [COLOR_W-1:0]  w_blend_color;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_slot_ok  = (int'(i_in_data.slot) < MAX_STOPS);
    assign w_slot_idx = IW'(i_in_data.slot);
    assign w_interp   = w_res.has_a && w_res.has_b && (w_res.pos_a != r_key);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.opcode == OP_LOOKUP) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (r_idx == IW'(MAX_STOPS - 1)) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                n_state = w_interp ? ST_BLEND : ST_DONE;
            end
            ST_BLEND: begin
                if (w_blend_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        w_wr_en       = w_accept && (i_in_data.opcode == OP_WRITE) && w_slot_ok;
        w_rd_en       = (r_state == ST_SCAN);
        w_blend_start = (r_state == ST_RESOLVE) && w_interp;
        w_load_out    = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_cmp_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_live <= w_rd_en;
            if (w_accept) begin
                case (i_in_data.opcode)
                    OP_WRITE: begin
                        if (w_slot_ok) begin
                            r_valid[w_slot_idx] <= 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (w_slot_ok) begin
                            r_valid[w_slot_idx] <= 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        r_valid <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        r_cmp_idx <= r_idx;
        if (w_accept) begin
            r_key   <= i_in_data.position;
            r_idx   <= '0;
            r_color <= '0;
            r_err   <= 1'b0;
            r_hit   <= (i_in_data.opcode == OP_DELETE) && w_slot_ok && r_valid[w_slot_idx];
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + IW'(1);
        end else if (r_state == ST_RESOLVE) begin
            if (!w_res.has_a && !w_res.has_b) begin
                r_err <= 1'b1;
            end else if (!w_res.has_a) begin
                r_hit   <= 1'b1;
                r_color <= w_res.color_b;
            end else if (!w_interp) begin
                r_hit   <= 1'b1;
                r_color <= w_res.color_a;
            end
        end else if ((r_state == ST_BLEND) && w_blend_done) begin
            r_hit   <= 1'b1;
            r_color <= w_blend_color;
        end

        if (w_load_out) begin
            r_out.color_out   <= r_color;
            r_out.hit         <= r_hit;
            r_out.empty_error <= r_err;
        end
    end

    cgsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot_idx),
        .i_wr_data ({i_in_data.position, i_in_data.color}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    cgsl_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_accept),
        .i_live  (r_cmp_live),
        .i_valid (r_valid[r_cmp_idx]),
        .i_pos   (w_rd_data[ENTRY_W-1:COLOR_W]),
        .i_color (w_rd_data[COLOR_W-1:0]),
        .i_key   (r_key),
        .o_res   (w_res)
    );

    cgsl_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_blend_start),
        .i_res   (w_res),
        .i_key   (r_key),
        .o_done  (w_blend_done),
        .o_color (w_blend_color)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/cgsl_ram.sv]
// ----------------------------------------------------------------------------
// cgsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cgsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/cgsl_scan.sv]
// ----------------------------------------------------------------------------
// cgsl_scan
// Tracks the bracketing stops (last at or below key, first above) over a scan.
// ----------------------------------------------------------------------------
module cgsl_scan
    import cgsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_live,
    input  logic               i_valid,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [POS_W-1:0]   i_key,
    output t_scan_res          o_res
);

    t_scan_res r_res;
    logic      w_below;
    logic      w_take_a;
    logic      w_take_b;

    assign w_below  = (i_pos <= i_key);
    assign w_take_a = i_live && i_valid && w_below && (!r_res.has_a || i_pos >= r_res.pos_a);
    assign w_take_b = i_live && i_valid && !w_below && (!r_res.has_b || i_pos < r_res.pos_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.has_a <= 1'b0;
            r_res.has_b <= 1'b0;
        end else if (i_clear) begin
            r_res.has_a <= 1'b0;
            r_res.has_b <= 1'b0;
        end else begin
            if (w_take_a) begin
                r_res.has_a <= 1'b1;
            end
            if (w_take_b) begin
                r_res.has_b <= 1'b1;
            end
        end
        if (w_take_a) begin
            r_res.pos_a   <= i_pos;
            r_res.color_a <= i_color;
        end
        if (w_take_b) begin
            r_res.pos_b   <= i_pos;
            r_res.color_b <= i_color;
        end
    end

    assign o_res = r_res;

endmodule

[hdl/cgsl_blend.sv]
// ----------------------------------------------------------------------------
// cgsl_blend
// Per-channel linear blend: shared multiplier, then restoring divide by span.
// ----------------------------------------------------------------------------
module cgsl_blend
    import cgsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_scan_res          i_res,
    input  logic [POS_W-1:0]   i_key,
    output logic               o_done,
    output logic [COLOR_W-1:0] o_color
);

    t_blend_ph            r_ph;
    t_blend_ph            n_ph;
    logic [1:0]           r_ch;
    logic [2:0]           r_step;
    logic [POS_W-1:0]     r_da;
    logic [POS_W-1:0]     r_db;
    logic [POS_W-1:0]     r_span;
    logic [DVS_W-1:0]     r_dvs;
    logic [PROD_W-1:0]    r_num;
    logic [CH_W-1:0]      r_q;
    logic [COLOR_W-1:0]   r_ca;
    logic [COLOR_W-1:0]   r_cb;
    logic [COLOR_W-1:0]   r_res;
    logic                 r_done;
    logic                 n_done;

    logic [CH_W-1:0]      w_m_a;
    logic [POS_W-1:0]     w_m_b;
    logic [PROD_W-1:0]    w_prod;
    logic [PROD_W-1:0]    w_trial;
    logic                 w_qbit;
    logic [CH_W-1:0]      w_q_next;

    assign w_m_a    = (r_ph == BL_MUL0) ? r_ca[CH_W-1:0] : r_cb[CH_W-1:0];
    assign w_m_b    = (r_ph == BL_MUL0) ? r_db : r_da;
    assign w_prod   = PROD_W'(w_m_a * w_m_b);
    assign w_trial  = PROD_W'(r_dvs);
    assign w_qbit   = (r_num >= w_trial);
    assign w_q_next = {r_q[CH_W-2:0], w_qbit};

    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            BL_IDLE: begin
                if (i_start) begin
                    n_ph = BL_MUL0;
                end
            end
            BL_MUL0: begin
                n_ph = BL_MUL1;
            end
            BL_MUL1: begin
                n_ph = BL_DIV;
            end
            BL_DIV: begin
                if (r_step == 3'd0) begin
                    if (r_ch == 2'(NUM_CH - 1)) begin
                        n_ph = BL_IDLE;
                    end else begin
                        n_ph = BL_MUL0;
                    end
                end
            end
            default: begin
                n_ph = BL_IDLE;
            end
        endcase
    end

    always_comb begin
        n_done = (r_ph == BL_DIV) && (r_step == 3'd0) && (r_ch == 2'(NUM_CH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= BL_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end

        case (r_ph)
            BL_IDLE: begin
                if (i_start) begin
                    r_da   <= i_key - i_res.pos_a;
                    r_db   <= i_res.pos_b - i_key;
                    r_span <= i_res.pos_b - i_res.pos_a;
                    r_ca   <= i_res.color_a;
                    r_cb   <= i_res.color_b;
                    r_ch   <= 2'd0;
                end
            end
            BL_MUL0: begin
                r_num <= w_prod;
            end
            BL_MUL1: begin
                r_num  <= r_num + w_prod;
                r_dvs  <= {r_span, {(CH_W-1){1'b0}}};
                r_step <= 3'd7;
            end
            BL_DIV: begin
                if (w_qbit) begin
                    r_num <= r_num - w_trial;
                end
                r_q    <= w_q_next;
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 3'd1;
                if (r_step == 3'd0) begin
                    r_res <= {w_q_next, r_res[COLOR_W-1:CH_W]};
                    r_ca  <= r_ca >> CH_W;
                    r_cb  <= r_cb >> CH_W;
                    r_ch  <= r_ch + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_color = r_res;

endmodule
